/* hdl/ecnwcc_pkg.sv */
// ----------------------------------------------------------------------------
// ecnwcc_pkg
// Shared types and constants of the DCTCP-style congestion window block.
// ----------------------------------------------------------------------------
`default_nettype none

package ecnwcc_pkg;

    localparam int unsigned PAYLOAD_BYTES = 1024;
    localparam logic [31:0] ONE_Q16       = 32'h0001_0000;
    localparam logic [16:0] ALPHA_ONE     = 17'h1_0000;

    localparam logic OP_ACK     = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic [1:0] CFG_INIT_WINDOW    = 2'd0;
    localparam logic [1:0] CFG_INIT_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_INIT_LAST_ACK  = 2'd2;
    localparam logic [1:0] CFG_TOTAL_BYTES    = 2'd3;

    typedef enum logic [1:0] {
        CLS_NEW     = 2'd0,
        CLS_DUP     = 2'd1,
        CLS_OLD     = 2'd2,
        CLS_TIMEOUT = 2'd3
    } t_cls;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAC,
        ST_SCALE,
        ST_SUB,
        ST_GROW,
        ST_GDIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        op;
        logic [31:0] ack_number;
        logic        ecn_echo;
    } t_req;

endpackage

`default_nettype wire

/* hdl/ecnwcc_req_if.sv */
// ----------------------------------------------------------------------------
// ecnwcc_req_if
// Event request channel: valid/ready with op, ack number and ECN echo.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecnwcc_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] ack_number;
    logic        ecn_echo;

    modport source (output valid, output op, output ack_number, output ecn_echo,
                    input ready);
    modport sink   (input valid, input op, input ack_number, input ecn_echo,
                    output ready);
endinterface

`default_nettype wire

/* hdl/ecnwcc_rsp_if.sv */
// ----------------------------------------------------------------------------
// ecnwcc_rsp_if
// Result channel: valid/ready with the window state after each event.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecnwcc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  ack_class;
    logic [31:0] window_out;
    logic [31:0] threshold_out;
    logic [16:0] alpha_out;
    logic [31:0] bytes_remaining;
    logic        fast_retransmit;

    modport source (output valid, output ack_class, output window_out,
                    output threshold_out, output alpha_out, output bytes_remaining,
                    output fast_retransmit, input ready);
    modport sink   (input valid, input ack_class, input window_out,
                    input threshold_out, input alpha_out, input bytes_remaining,
                    input fast_retransmit, output ready);
endinterface

`default_nettype wire

/* hdl/ecnwcc_div.sv */
// ----------------------------------------------------------------------------
// ecnwcc_div
// Radix-4 restoring divider: q = floor(n * 2^32 / d) for n < d.
// ----------------------------------------------------------------------------
`default_nettype none

module ecnwcc_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_n,
    input  wire  [31:0] i_d,
    output logic        o_done,
    output logic [31:0] o_q
);

    logic [31:0] r_rem, n_rem;
    logic [31:0] r_q, n_q;
    logic [31:0] r_d;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    always_comb begin
        logic [32:0] t;
        n_rem = r_rem;
        n_q   = r_q;
        for (int k = 0; k < 2; k++) begin
            t = {n_rem, 1'b0};
            if (t >= {1'b0, r_d}) begin
                t   = t - {1'b0, r_d};
                n_q = {n_q[30:0], 1'b1};
            end else begin
                n_q = {n_q[30:0], 1'b0};
            end
            n_rem = t[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= i_n;
            r_q   <= '0;
            r_d   <= i_d;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

`default_nettype wire

/* hdl/ecnwcc_front.sv */
// ----------------------------------------------------------------------------
// ecnwcc_front
// Request intake: two-entry queue between the input channel and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ecnwcc_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    ecnwcc_req_if.sink        i_req,
    output logic              o_q_valid,
    output ecnwcc_pkg::t_req  o_q_data,
    input  wire               i_q_pop
);

    ecnwcc_pkg::t_req r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign i_req.ready = (r_count != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_q_pop && (r_count != 2'd0);
    assign o_q_valid   = (r_count != 2'd0);
    assign o_q_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{op: i_req.op, ack_number: i_req.ack_number,
                                 ecn_echo: i_req.ecn_echo};
        end
    end

endmodule

`default_nettype wire

/* hdl/ecnwcc_back.sv */
// ----------------------------------------------------------------------------
// ecnwcc_back
// Event engine: classifies each request, updates window state through a
// sequencer with one shared divider, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ecnwcc_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_q_valid,
    input  ecnwcc_pkg::t_req  i_q_data,
    output logic              o_q_pop,
    input  wire               i_cfg_we,
    input  wire  [1:0]        i_cfg_index,
    input  wire  [31:0]       i_cfg_data,
    ecnwcc_rsp_if.source      o_rsp,
    output logic              o_div_start,
    output logic              o_div_done
);

    ecnwcc_pkg::t_state r_state, n_state;

    logic [31:0] r_window, n_window;
    logic [31:0] r_thr, n_thr;
    logic [16:0] r_alpha, n_alpha;
    logic [31:0] r_last, n_last;
    logic [15:0] r_dup, n_dup;
    logic        r_active, n_active;
    logic [15:0] r_acks_in, n_acks_in;
    logic [15:0] r_acks_left, n_acks_left;
    logic [15:0] r_marked, n_marked;
    logic [31:0] r_remain, n_remain;
    logic [31:0] r_j, n_j;
    logic [48:0] r_prod, n_prod;
    ecnwcc_pkg::t_cls r_cls, n_cls;
    logic        r_fr, n_fr;

    logic        r_out_valid;
    logic [1:0]  r_o_cls;
    logic [31:0] r_o_window;
    logic [31:0] r_o_thr;
    logic [16:0] r_o_alpha;
    logic [31:0] r_o_remain;
    logic        r_o_fr;
    logic        load_out;

    logic        div_start;
    logic [31:0] div_n, div_d;
    logic        div_done;
    logic [31:0] div_q;

    ecnwcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_n     (div_n),
        .i_d     (div_d),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_comb begin
        logic [15:0] m;
        logic [47:0] used;
        logic [48:0] sum49;
        logic [32:0] s33;
        logic [17:0] a18;
        logic [15:0] dup1;

        n_state     = r_state;
        n_window    = r_window;
        n_thr       = r_thr;
        n_alpha     = r_alpha;
        n_last      = r_last;
        n_dup       = r_dup;
        n_active    = r_active;
        n_acks_in   = r_acks_in;
        n_acks_left = r_acks_left;
        n_marked    = r_marked;
        n_remain    = r_remain;
        n_j         = r_j;
        n_prod      = r_prod;
        n_cls       = r_cls;
        n_fr        = r_fr;
        o_q_pop     = 1'b0;
        div_start   = 1'b0;
        div_n       = '0;
        div_d       = '0;
        load_out    = 1'b0;
        m           = (r_marked > r_acks_in) ? r_acks_in : r_marked;
        used        = {16'd0, i_q_data.ack_number - r_last} *
                      48'(ecnwcc_pkg::PAYLOAD_BYTES);
        sum49       = {17'd0, r_window} + {1'b0, r_j, 16'd0};
        s33         = {1'b0, r_window} + {1'b0, div_q};
        a18         = '0;
        dup1        = r_dup + 16'd1;

        case (r_state)
            ecnwcc_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_fr    = 1'b0;
                    n_state = ecnwcc_pkg::ST_DONE;
                    if (i_q_data.op == ecnwcc_pkg::OP_TIMEOUT) begin
                        n_cls    = ecnwcc_pkg::CLS_TIMEOUT;
                        n_thr    = {1'b0, r_window[31:1]};
                        n_window = ecnwcc_pkg::ONE_Q16;
                    end else if (i_q_data.ack_number < r_last) begin
                        n_cls = ecnwcc_pkg::CLS_OLD;
                    end else if (i_q_data.ack_number == r_last) begin
                        n_cls = ecnwcc_pkg::CLS_DUP;
                        n_dup = dup1;
                        if (!dup1[0]) begin
                            n_window = {1'b0, r_window[31:1]};
                            n_thr    = {1'b0, r_window[31:1]};
                            n_fr     = 1'b1;
                        end
                    end else begin
                        n_cls  = ecnwcc_pkg::CLS_NEW;
                        n_dup  = '0;
                        n_j    = i_q_data.ack_number - r_last;
                        n_last = i_q_data.ack_number;
                        if (r_remain != 32'd0) begin
                            n_remain = (used >= {16'd0, r_remain}) ? 32'd0
                                     : r_remain - used[31:0];
                        end
                        if (r_active) begin
                            n_state = ecnwcc_pkg::ST_GROW;
                            if (r_acks_left != 16'd0) begin
                                n_acks_left = r_acks_left - 16'd1;
                                n_marked    = r_marked + 16'(i_q_data.ecn_echo);
                            end else begin
                                n_active = 1'b0;
                            end
                        end else if (r_acks_in != 16'd0) begin
                            if (m == r_acks_in) begin
                                a18     = {1'b0, r_alpha} + {1'b0, ecnwcc_pkg::ALPHA_ONE};
                                n_alpha = a18[17:1];
                                n_state = ecnwcc_pkg::ST_SCALE;
                            end else begin
                                div_start = 1'b1;
                                div_n     = {16'd0, m};
                                div_d     = {16'd0, r_acks_in};
                                n_state   = ecnwcc_pkg::ST_FRAC;
                            end
                        end else begin
                            n_state = ecnwcc_pkg::ST_SCALE;
                        end
                    end
                end
            end
            ecnwcc_pkg::ST_FRAC: begin
                if (div_done) begin
                    a18     = {1'b0, r_alpha} + {2'd0, div_q[31:16]};
                    n_alpha = a18[17:1];
                    n_state = ecnwcc_pkg::ST_SCALE;
                end
            end
            ecnwcc_pkg::ST_SCALE: begin
                n_acks_in   = r_window[31:16];
                n_acks_left = r_window[31:16];
                n_marked    = '0;
                n_active    = 1'b1;
                n_prod      = r_window * r_alpha;
                n_state     = ecnwcc_pkg::ST_SUB;
            end
            ecnwcc_pkg::ST_SUB: begin
                n_window = r_window - r_prod[48:17];
                n_state  = ecnwcc_pkg::ST_GROW;
            end
            ecnwcc_pkg::ST_GROW: begin
                n_state = ecnwcc_pkg::ST_DONE;
                if (sum49 < {17'd0, r_thr}) begin
                    n_window = sum49[31:0];
                end else if (r_window < r_thr) begin
                    n_window = r_thr;
                end else if (r_j >= r_window) begin
                    n_window = '1;
                end else begin
                    div_start = 1'b1;
                    div_n     = r_j;
                    div_d     = r_window;
                    n_state   = ecnwcc_pkg::ST_GDIV;
                end
            end
            ecnwcc_pkg::ST_GDIV: begin
                if (div_done) begin
                    n_window = s33[32] ? 32'hFFFF_FFFF : s33[31:0];
                    n_state  = ecnwcc_pkg::ST_DONE;
                end
            end
            ecnwcc_pkg::ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = ecnwcc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ecnwcc_pkg::ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_index)
                ecnwcc_pkg::CFG_INIT_WINDOW:    n_window = {i_cfg_data[15:0], 16'd0};
                ecnwcc_pkg::CFG_INIT_THRESHOLD: n_thr    = {i_cfg_data[15:0], 16'd0};
                ecnwcc_pkg::CFG_INIT_LAST_ACK:  n_last   = i_cfg_data;
                ecnwcc_pkg::CFG_TOTAL_BYTES:    n_remain = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ecnwcc_pkg::ST_IDLE;
            r_window    <= ecnwcc_pkg::ONE_Q16;
            r_thr       <= {16'd1000, 16'd0};
            r_alpha     <= '0;
            r_last      <= 32'd2;
            r_dup       <= '0;
            r_active    <= 1'b0;
            r_acks_in   <= '0;
            r_acks_left <= '0;
            r_marked    <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_thr       <= n_thr;
            r_alpha     <= n_alpha;
            r_last      <= n_last;
            r_dup       <= n_dup;
            r_active    <= n_active;
            r_acks_in   <= n_acks_in;
            r_acks_left <= n_acks_left;
            r_marked    <= n_marked;
            r_remain    <= n_remain;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_prod <= n_prod;
        r_cls  <= n_cls;
        r_fr   <= n_fr;
        if (load_out) begin
            r_o_cls    <= r_cls;
            r_o_window <= r_window;
            r_o_thr    <= r_thr;
            r_o_alpha  <= r_alpha;
            r_o_remain <= r_remain;
            r_o_fr     <= r_fr;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.ack_class       = r_o_cls;
    assign o_rsp.window_out      = r_o_window;
    assign o_rsp.threshold_out   = r_o_thr;
    assign o_rsp.alpha_out       = r_o_alpha;
    assign o_rsp.bytes_remaining = r_o_remain;
    assign o_rsp.fast_retransmit = r_o_fr;
    assign o_div_start           = div_start;
    assign o_div_done            = div_done;

endmodule

`default_nettype wire

/* hdl/ecn_window_congestion_control.sv */
// ----------------------------------------------------------------------------
// ecn_window_congestion_control
// DCTCP-style sender congestion window, one result per event request.
//
// Channels: i_req carries events (op 0 ack, 1 timeout), o_rsp returns the
// class and the window, threshold, alpha, remaining bytes and fast
// retransmit flag after the event. A two-entry queue takes requests while
// the engine works; a result register holds the answer until taken.
// Timeout, duplicate and old acks go from the queue straight to the result
// register; a new ack may take up to two passes through the shared radix-4
// divider (alpha fraction, then the avoidance increment), plus the multiply
// and subtract stages.
// Configuration writes (i_cfg_we) load the window, threshold, last ack or
// byte count at once; write only while idle.
// Reset: window 1 packet, threshold 1000, last ack 2, nothing remaining,
// queue and result register empty. When o_rsp is stalled the engine
// holds its finished result and the queue fills, then i_req.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ecn_window_congestion_control (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ecnwcc_req_if.sink   i_req,
    ecnwcc_rsp_if.source o_rsp,
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [31:0]  i_cfg_data
);

    logic             q_valid;
    ecnwcc_pkg::t_req q_data;
    logic             q_pop;
    logic             div_start;
    logic             div_done;
    logic             r_div_busy;

    ecnwcc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_valid (q_valid),
        .o_q_data  (q_data),
        .i_q_pop   (q_pop)
    );

    ecnwcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rsp       (o_rsp),
        .o_div_start (div_start),
        .o_div_done  (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (div_start) begin
            r_div_busy <= 1'b1;
        end else if (div_done) begin
            r_div_busy <= 1'b0;
        end
    end

    a_fr_only_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.fast_retransmit |-> o_rsp.ack_class == ecnwcc_pkg::CLS_DUP)
        else $error("fast retransmit on a non-duplicate result");

    a_timeout_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.ack_class == ecnwcc_pkg::CLS_TIMEOUT
        |-> o_rsp.window_out == ecnwcc_pkg::ONE_Q16)
        else $error("timeout result without a one-packet window");

    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.alpha_out <= ecnwcc_pkg::ALPHA_ONE)
        else $error("alpha above one");

    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> !div_start)
        else $error("divider started while busy");

endmodule

`default_nettype wire
